// File: hw/rtl/brb_pkg.sv
// shared types, request codes and controller state for the byte ring buffer
`timescale 1ns / 1ps

package brb_pkg;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  write_byte;
        logic [10:0] count;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [10:0] moved;
        logic [10:0] fill_level;
        logic        byte_valid;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_LOAD
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_issue;
        logic rd_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic burst_start;
        logic burst_done;
    } dp_status_t;

endpackage

// File: hw/rtl/brb_controller.sv
// request sequencer state machine for the byte ring buffer
`timescale 1ns / 1ps

module brb_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  brb_pkg::dp_status_t status,
    output brb_pkg::ctrl_cmd_t  cmd
);
    import brb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && status.out_free && status.burst_start)
                begin
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_RD_ISSUE:
            begin
                state_next = ST_RD_LOAD;
            end
            ST_RD_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = status.burst_done ? ST_IDLE : ST_RD_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = !status.out_free;
                cmd.take  = req_valid && status.out_free;
            end
            ST_RD_ISSUE:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_RD_LOAD:
            begin
                cmd.rd_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/brb_datapath.sv
// storage, pointers, fill count, burst counters and result register
`timescale 1ns / 1ps

module brb_datapath #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  brb_pkg::in_item_t   req_data,
    input  brb_pkg::ctrl_cmd_t  cmd,
    output brb_pkg::dp_status_t status,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output brb_pkg::out_item_t  rsp_data
);
    import brb_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > 11) ? CW : 11;
    localparam int SW = PW + 2;
    localparam int BW = $clog2(MAX_BURST + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
    localparam logic [MW-1:0] BURST_M   = MW'(MAX_BURST);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] wp_next;
    logic [PW-1:0] rp_reg;
    logic [PW-1:0] rp_next;
    logic [CW-1:0] stored_reg;
    logic [CW-1:0] stored_next;
    logic [BW-1:0] n_reg;
    logic [BW-1:0] n_next;
    logic [BW-1:0] k_reg;
    logic [BW-1:0] k_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    out_item_t     out_reg;
    out_item_t     out_next;
    logic          wr_en;

    logic [MW-1:0] count_m;
    logic [MW-1:0] stored_m;
    logic [MW-1:0] cap_m;
    logic [MW-1:0] burst_m;
    logic [MW-1:0] drain_m;
    logic [CW-1:0] drain_c;
    logic [SW-1:0] rp_sum;
    logic [PW-1:0] rp_drain;
    logic          full;

    assign count_m  = MW'(req_data.count);
    assign stored_m = MW'(stored_reg);
    assign cap_m    = (count_m > BURST_M) ? BURST_M : count_m;
    assign burst_m  = (cap_m > stored_m) ? stored_m : cap_m;
    assign drain_m  = (count_m > stored_m) ? stored_m : count_m;
    assign drain_c  = drain_m[CW-1:0];
    assign rp_sum   = SW'(rp_reg) + SW'(drain_c);
    assign rp_drain = (rp_sum >= DEPTH_S) ? PW'(rp_sum - DEPTH_S) : PW'(rp_sum);
    assign full     = (stored_reg == DEPTH_C);

    assign status.out_free    = !out_valid_reg || !rsp_stall;
    assign status.burst_start = (req_data.req_type == REQ_READ) && (burst_m != '0);
    assign status.burst_done  = (k_reg == n_reg);

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        stored_next    = stored_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.take)
        begin
            out_next            = '0;
            out_next.last       = 1'b1;
            out_next.fill_level = stored_m[10:0];
            case (req_data.req_type)
                REQ_WRITE:
                begin
                    out_valid_next = 1'b1;
                    if (!full)
                    begin
                        wr_en               = 1'b1;
                        wp_next             = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                        stored_next         = stored_reg + 1'b1;
                        out_next.moved      = 11'd1;
                        out_next.fill_level = 11'(stored_next);
                    end
                end
                REQ_READ:
                begin
                    n_next = burst_m[BW-1:0];
                    k_next = '0;
                    if (burst_m == '0)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
                REQ_DRAIN:
                begin
                    out_valid_next      = 1'b1;
                    rp_next             = rp_drain;
                    stored_next         = stored_reg - drain_c;
                    out_next.moved      = drain_m[10:0];
                    out_next.fill_level = 11'(stored_next);
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
        end

        if (cmd.rd_issue)
        begin
            rp_next     = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
            stored_next = stored_reg - 1'b1;
            k_next      = k_reg + 1'b1;
        end

        if (cmd.rd_load)
        begin
            out_valid_next      = 1'b1;
            out_next.data_byte  = rd_data_reg;
            out_next.moved      = 11'(k_reg);
            out_next.fill_level = stored_m[10:0];
            out_next.byte_valid = 1'b1;
            out_next.last       = (k_reg == n_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            stored_reg    <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            stored_reg    <= stored_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= req_data.write_byte;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rp_reg];
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= DEPTH_C)
        else $error("fill count beyond depth");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= n_reg)
        else $error("burst counter past burst length");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take || cmd.rd_load) |-> (!out_valid_reg || !rsp_stall))
        else $error("result register loaded over a pending transfer");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |-> (stored_reg != '0))
        else $error("memory read issued with nothing stored");

endmodule

// File: hw/rtl/byte_ring_buffer_core.sv
// byte ring buffer top level: controller and datapath
// write, drain, unused or empty read: result registered in the cycle after the transfer,
// one request per cycle while the result side keeps up
// read burst of n bytes: for each byte the memory read register and the result
// register load alternate; the next request is taken once the last byte is loaded
// reset clears pointers, fill count, burst counters, state and result valid; storage
// is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module byte_ring_buffer_core #(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  brb_pkg::in_item_t  req_data,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output brb_pkg::out_item_t rsp_data
);
    import brb_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    brb_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    brb_datapath #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule
